### hdl/sit_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants of the string intern table: status codes,
// sequencer states and the control and result bundles between the modules.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int HASH_IN_W = 32;
  localparam int LEN_W     = 16;
  localparam int NEED_W    = 17;
  localparam int ADDR_W    = 16;
  localparam int GROUP     = 16;

  localparam logic [NEED_W-1:0] BLOCK_BYTES_RESET = 17'd4096;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_FOUND     = 3'd1,
    ST_FULL      = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_DEC,
    S_OUT
  } state_t;

  // one pulse per phase of an item (commit only for a new string), shared by chain and allocator
  typedef struct packed {
    logic capture;
    logic reduce;
    logic commit;
  } step_ctl_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } lookup_t;

  typedef struct packed {
    logic              too_long;
    logic              exhausted;
    logic [ADDR_W-1:0] addr;
  } alloc_t;

endpackage : sit_pkg
`default_nettype wire

### hdl/sit_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sit_cell
// One slot of the sorted table. Compares its hash with the key and, on
// commit, keeps its entry, takes its lower neighbor's, or takes the new one.
// ----------------------------------------------------------------------------
module sit_cell
  import sit_pkg::*;
#(
  parameter int KEY_W = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire step_ctl_t         ctl,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic [ADDR_W-1:0] new_addr,
  input  wire logic [KEY_W-1:0]  prev_hash,
  input  wire logic [ADDR_W-1:0] prev_addr,
  input  wire logic              prev_valid,
  input  wire logic              prev_lt,
  output logic      [KEY_W-1:0]  hash,
  output logic      [ADDR_W-1:0] addr,
  output logic                   valid,
  output logic                   lt,
  output logic                   eq
);

  logic lt_next;
  logic eq_next;

  assign lt_next = valid && (hash < key);
  assign eq_next = valid && (hash == key);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      lt <= lt_next;
      eq <= eq_next;
    end
  end

  // insertion: cells at or above the insert point move up by one
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.commit && !lt) begin
      if (prev_lt) begin
        hash  <= key;
        addr  <= new_addr;
        valid <= 1'b1;
      end else begin
        hash  <= prev_hash;
        addr  <= prev_addr;
        valid <= prev_valid;
      end
    end
  end

endmodule : sit_cell
`default_nettype wire

### hdl/sit_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sit_chain
// Row of table cells kept sorted ascending, plus a two-level or-tree,
// registered after its first level, that pulls out the address of the matching cell.
// ----------------------------------------------------------------------------
module sit_chain
  import sit_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int KEY_W         = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire step_ctl_t         ctl,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic [ADDR_W-1:0] new_addr,
  output lookup_t                found
);

  localparam int GROUPS = (TABLE_ENTRIES + GROUP - 1) / GROUP;
  localparam int PADDED = GROUPS * GROUP;

  logic [KEY_W-1:0]  hash_v  [TABLE_ENTRIES];
  logic [ADDR_W-1:0] addr_v  [TABLE_ENTRIES];
  logic              valid_v [TABLE_ENTRIES];
  logic              lt_v    [TABLE_ENTRIES];
  logic              eq_v    [TABLE_ENTRIES];

  logic [PADDED-1:0] eq_pad;
  logic [ADDR_W-1:0] addr_pad [PADDED];

  logic              grp_hit  [GROUPS];
  logic [ADDR_W-1:0] grp_addr [GROUPS];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0]  p_hash;
    logic [ADDR_W-1:0] p_addr;
    logic              p_valid;
    logic              p_lt;

    if (i == 0) begin : g_first
      // below the first cell everything counts as smaller than the key
      assign p_hash  = '0;
      assign p_addr  = '0;
      assign p_valid = 1'b0;
      assign p_lt    = 1'b1;
    end else begin : g_rest
      assign p_hash  = hash_v[i-1];
      assign p_addr  = addr_v[i-1];
      assign p_valid = valid_v[i-1];
      assign p_lt    = lt_v[i-1];
    end

    sit_cell #(
      .KEY_W (KEY_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .key        (key),
      .new_addr   (new_addr),
      .prev_hash  (p_hash),
      .prev_addr  (p_addr),
      .prev_valid (p_valid),
      .prev_lt    (p_lt),
      .hash       (hash_v[i]),
      .addr       (addr_v[i]),
      .valid      (valid_v[i]),
      .lt         (lt_v[i]),
      .eq         (eq_v[i])
    );
  end

  for (genvar k = 0; k < PADDED; k++) begin : g_pad
    if (k < TABLE_ENTRIES) begin : g_real
      assign eq_pad[k]   = eq_v[k];
      assign addr_pad[k] = eq_v[k] ? addr_v[k] : '0;
    end else begin : g_fill
      assign eq_pad[k]   = 1'b0;
      assign addr_pad[k] = '0;
    end
  end

  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    logic              hit_c;
    logic [ADDR_W-1:0] addr_c;

    always_comb begin
      hit_c  = 1'b0;
      addr_c = '0;
      for (int j = 0; j < GROUP; j++) begin
        hit_c  = hit_c | eq_pad[g*GROUP + j];
        addr_c = addr_c | addr_pad[g*GROUP + j];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.reduce) begin
        grp_hit[g]  <= hit_c;
        grp_addr[g] <= addr_c;
      end
    end
  end

  // at most one cell matches, so or-ing the masked addresses selects it
  always_comb begin
    found = '0;
    for (int g = 0; g < GROUPS; g++) begin
      found.hit  = found.hit | grp_hit[g];
      found.addr = found.addr | grp_addr[g];
    end
  end

`ifndef SYNTHESIS
  for (genvar a = 1; a < TABLE_ENTRIES; a++) begin : g_chk
    // occupied cells form a prefix and stay in ascending order
    ast_prefix: assert property (@(posedge clk) disable iff (rst)
      valid_v[a] |-> valid_v[a-1])
      else $error("table hole below occupied cell");
    ast_sorted: assert property (@(posedge clk) disable iff (rst)
      valid_v[a] |-> (hash_v[a-1] < hash_v[a]))
      else $error("table out of order");
  end
  ast_one_hit: assert property (@(posedge clk) disable iff (rst)
    ctl.reduce |-> $onehot0(eq_pad))
    else $error("more than one matching cell");
`endif

endmodule : sit_chain
`default_nettype wire

### hdl/sit_alloc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sit_alloc
// Bump allocator over fixed-size arena blocks. Works out, in two registered
// steps, where a new string would go and whether it fits; commits on insert.
// ----------------------------------------------------------------------------
module sit_alloc
  import sit_pkg::*;
#(
  parameter int ARENA_BYTES = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire step_ctl_t         ctl,
  input  wire logic [NEED_W-1:0] need,
  input  wire logic [NEED_W-1:0] block_size,
  output alloc_t                 res
);

  localparam int ARENA_W = $clog2(ARENA_BYTES + 1);
  localparam int SW      = ((ARENA_W > NEED_W) ? ARENA_W : NEED_W) + 2;
  localparam logic [SW-1:0] ARENA_LIMIT = SW'(ARENA_BYTES);

  logic [SW-1:0] base;
  logic [SW-1:0] fill;

  // first step
  logic [SW-1:0] bb_w;
  logic [SW-1:0] need_w;
  logic [SW-1:0] room_span;
  logic          roll_c;
  logic          roll;
  logic [SW-1:0] base1;
  logic [SW-1:0] fill1;
  logic          too_long;

  // second step
  logic          exhausted;
  logic [SW-1:0] addr1;
  logic [SW-1:0] fill2;

  assign bb_w      = SW'(block_size);
  assign need_w    = SW'(need);
  assign room_span = (bb_w > fill) ? bb_w : fill;
  assign roll_c    = (fill > bb_w) || ((bb_w - fill) < need_w);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      too_long <= need > block_size;
      roll     <= roll_c;
      // a fresh block starts past whatever the old one really used
      base1    <= roll_c ? (base + room_span) : base;
      fill1    <= roll_c ? '0 : fill;
    end
    if (ctl.reduce) begin
      exhausted <= (roll && ((base1 + bb_w) > ARENA_LIMIT)) ||
                   ((base1 + fill1 + need_w) > ARENA_LIMIT);
      addr1     <= base1 + fill1;
      fill2     <= fill1 + need_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      fill <= '0;
    end else if (ctl.commit) begin
      base <= base1;
      fill <= fill2;
    end
  end

  assign res.too_long  = too_long;
  assign res.exhausted = exhausted;
  assign res.addr      = addr1[ADDR_W-1:0];

`ifndef SYNTHESIS
  ast_in_arena: assert property (@(posedge clk) disable iff (rst)
    (base + fill) <= ARENA_LIMIT)
    else $error("allocation pointer past arena end");
  ast_commit_fits: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> !too_long && !exhausted)
    else $error("commit of a string that does not fit");
  ast_base_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> base >= $past(base))
    else $error("block base moved backward");
`endif

endmodule : sit_alloc
`default_nettype wire

### hdl/string_intern_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// string_intern_table_top
// Interns string hashes in a sorted table of cells and hands out arena
// addresses from a bump allocator of fixed-size blocks.
// ----------------------------------------------------------------------------
// sequence: an accepted input beat steps through S_CMP, S_RED and S_DEC, and
//   the result beat is valid in S_OUT; S_CMP registers the compare, S_RED the
//   first level of the two-level match tree, and S_DEC commits the insert shift
// one item in flight at a time; in_ready is low until its result beat is taken
// reset: table empty, arena pointer at 0, block_bytes back to 4096; no sweep
// ----------------------------------------------------------------------------
module string_intern_table_top
  import sit_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int ARENA_BYTES   = 65536,
  parameter int HASH_BITS     = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [NEED_W-1:0]    block_bytes,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [HASH_IN_W-1:0] string_hash,
  input  wire logic [LEN_W-1:0]     string_length,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [2:0]           status,
  output logic      [ADDR_W-1:0]    string_address
);

  localparam int KEY_W = (HASH_BITS < HASH_IN_W) ? HASH_BITS : HASH_IN_W;
  localparam int CW    = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(TABLE_ENTRIES);

  state_t state;
  state_t state_next;

  logic [NEED_W-1:0] block_size;
  logic [KEY_W-1:0]  key;
  logic [NEED_W-1:0] need;
  logic [CW-1:0]     count;
  status_t           out_status;
  logic [ADDR_W-1:0] out_addr;

  step_ctl_t ctl;
  lookup_t   found;
  alloc_t    alloc;
  status_t   status_c;
  logic      full;
  logic      in_beat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_beat   = in_valid && in_ready;
  assign full      = (count == COUNT_MAX);

  always_comb begin
    if (found.hit) begin
      status_c = ST_FOUND;
    end else if (full) begin
      status_c = ST_FULL;
    end else if (alloc.too_long) begin
      status_c = ST_TOO_LONG;
    end else if (alloc.exhausted) begin
      status_c = ST_EXHAUSTED;
    end else begin
      status_c = ST_NEW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctl         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_beat) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        ctl.capture = 1'b1;
        state_next  = S_RED;
      end
      S_RED: begin
        ctl.reduce = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        ctl.commit = (status_c == ST_NEW);
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BLOCK_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      block_size <= block_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.commit) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      key  <= string_hash[KEY_W-1:0];
      need <= NEED_W'(string_length) + NEED_W'(1);
    end
    if (state == S_DEC) begin
      out_status <= status_c;
      unique case (status_c)
        ST_FOUND: out_addr <= found.addr;
        ST_NEW:   out_addr <= alloc.addr;
        default:  out_addr <= '0;
      endcase
    end
  end

  assign status         = out_status;
  assign string_address = out_addr;

  sit_chain #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_W         (KEY_W)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .key      (key),
    .new_addr (alloc.addr),
    .found    (found)
  );

  sit_alloc #(
    .ARENA_BYTES (ARENA_BYTES)
  ) u_alloc (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .need       (need),
    .block_size (block_size),
    .res        (alloc)
  );

`ifndef SYNTHESIS
  ast_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_MAX)
    else $error("entry count past table size");
  ast_no_full_insert: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> !full && !found.hit)
    else $error("insert into full table or over a match");
  ast_count_step: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> count == $past(count) + CW'(1))
    else $error("entry count did not advance on insert");
  ast_err_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != ST_NEW) && (out_status != ST_FOUND)
      |-> string_address == '0)
    else $error("error beat with nonzero address");
`endif

endmodule : string_intern_table_top
`default_nettype wire

### tb/sv/string_intern_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_intern_table_top_tb
// Checks the string intern table against a predictor of its sorted hash table
// and bump arena. Directed beats cover lookup hits, sorted insertion, block
// rollover, shrunken and zero block sizes, arena and table limits. Random
// traffic then runs under several block sizes and handshake pressures.
// ----------------------------------------------------------------------------
module string_intern_table_top_tb;
  import sit_pkg::*;

  localparam int TABLE_ENTRIES = 256;
  localparam int ARENA_BYTES   = 65536;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 225;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] addr;
  } intern_result_t;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [NEED_W-1:0]    block_bytes   = BLOCK_BYTES_RESET;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic [HASH_IN_W-1:0] string_hash   = '0;
  logic [LEN_W-1:0]     string_length = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [2:0]           status;
  logic [ADDR_W-1:0]    string_address;

  // predicted table and arena
  logic [HASH_IN_W-1:0] table_hash [TABLE_ENTRIES];
  logic [ADDR_W-1:0]    table_addr [TABLE_ENTRIES];
  int unsigned          table_entries    = 0;
  longint unsigned      arena_base       = 0;
  longint unsigned      arena_fill       = 0;
  longint unsigned      arena_block_size = BLOCK_BYTES_RESET;

  intern_result_t pending_results[$];
  int unsigned    status_tally [5] = '{default: 0};
  int unsigned    items_sent    = 0;
  int unsigned    error_count   = 0;
  int unsigned    cycle_count   = 0;
  int unsigned    in_gap_pct    = 0;
  int unsigned    out_stall_pct = 0;

  string_intern_table_top uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .block_bytes    (block_bytes),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .string_hash    (string_hash),
    .string_length  (string_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .string_address (string_address)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 40) $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    intern_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: status %0d addr %0d",
                                  status, string_address));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status: expected %0d, got %0d", want.status, status));
        if (string_address !== want.addr)
          report_mismatch($sformatf("string_address: expected %0d, got %0d", want.addr,
                                    string_address));
      end
    end
  end

  // lookup, then full / too long / arena checks, then sorted insert
  function automatic intern_result_t intern_string(input logic [HASH_IN_W-1:0] hash,
                                                   input logic [LEN_W-1:0] len);
    intern_result_t  res;
    int unsigned     pos;
    int unsigned     i;
    longint unsigned need;
    longint unsigned base;
    longint unsigned fill;
    res.status = ST_NEW;
    res.addr   = '0;
    need = len;
    need = need + 1;
    base = arena_base;
    fill = arena_fill;
    pos  = 0;
    while (pos < table_entries && table_hash[pos] < hash) pos++;
    if (pos < table_entries && table_hash[pos] == hash) begin
      res.status = ST_FOUND;
      res.addr   = table_addr[pos];
      return res;
    end
    if (table_entries >= TABLE_ENTRIES) begin
      res.status = ST_FULL;
      return res;
    end
    if (need > arena_block_size) begin
      res.status = ST_TOO_LONG;
      return res;
    end
    if (fill > arena_block_size || arena_block_size - fill < need) begin
      // new block never overlaps what a larger old block already holds
      base = base + (arena_block_size > fill ? arena_block_size : fill);
      fill = 0;
      if (base + arena_block_size > ARENA_BYTES) begin
        res.status = ST_EXHAUSTED;
        return res;
      end
    end
    if (base + fill + need > ARENA_BYTES) begin
      res.status = ST_EXHAUSTED;
      return res;
    end
    res.addr = ADDR_W'(base + fill);
    for (i = table_entries; i > pos; i--) begin
      table_hash[i] = table_hash[i - 1];
      table_addr[i] = table_addr[i - 1];
    end
    table_hash[pos] = hash;
    table_addr[pos] = res.addr;
    table_entries++;
    arena_base = base;
    arena_fill = fill + need;
    return res;
  endfunction

  task automatic send_string(input logic [HASH_IN_W-1:0] hash, input logic [LEN_W-1:0] len);
    intern_result_t res;
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    string_hash   <= hash;
    string_length <= len;
    do @(posedge clk); while (!in_ready);
    res = intern_string(hash, len);
    pending_results.push_back(res);
    status_tally[int'(res.status)]++;
    items_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_block_bytes(input logic [NEED_W-1:0] value);
    wait_drain();
    cfg_valid   <= 1'b1;
    block_bytes <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    arena_block_size = value;
  endtask

  // mostly lengths that fit the current block, some too long
  function automatic logic [LEN_W-1:0] pick_length();
    longint unsigned fit_max;
    int unsigned     r;
    fit_max = (arena_block_size == 0) ? 0 : arena_block_size - 1;
    if (fit_max > 65535) fit_max = 65535;
    r = $urandom_range(0, 99);
    if (r < 70) return LEN_W'($urandom_range(0, fit_max < 31 ? fit_max : 31));
    if (r < 90) return LEN_W'($urandom_range(0, fit_max));
    return LEN_W'($urandom_range(fit_max < 65535 ? fit_max + 1 : 65535, 65535));
  endfunction

  // mostly repeats of stored hashes, some new ones, some next to stored ones
  function automatic logic [HASH_IN_W-1:0] pick_hash();
    int unsigned          idx;
    logic [HASH_IN_W-1:0] h;
    if (table_entries == 0) return $urandom();
    idx = $urandom_range(0, table_entries - 1);
    if ($urandom_range(0, 99) >= 12) return table_hash[idx];
    if ($urandom_range(0, 3) != 0) return $urandom();
    h = table_hash[idx];
    return $urandom_range(0, 1) ? h + 1'b1 : h - 1'b1;
  endfunction

  task automatic test_basic_insert();
    send_string(32'h8000_0000, 16'd10);    // first string at address 0
    send_string(32'h0000_0000, 16'd0);     // lowest hash, shifts the first up
    send_string(32'hFFFF_FFFF, 16'hFFFF);  // too long for a 4096 byte block
    send_string(32'hFFFF_FFFF, 16'd4095);  // fills a whole new block
    send_string(32'h8000_0000, 16'd3);     // hit, length ignored
    send_string(32'h0000_0000, 16'd0);
    send_string(32'h8000_0001, 16'd4096);  // one byte over the block
    send_string(32'h7FFF_FFFF, 16'd0);     // full block forces a rollover
    send_string(32'hFFFF_FFFF, 16'd0);
  endtask

  task automatic test_block_shrink();
    write_block_bytes(17'd16);
    send_string(32'h1234_5678, 16'd14);    // exactly fills the remaining room
    write_block_bytes(17'd4);
    send_string(32'hAAAA_AAAA, 16'd3);     // fill already past the smaller block
    send_string(32'hAAAA_AAAB, 16'd4);
  endtask

  task automatic test_zero_block();
    write_block_bytes(17'd0);
    send_string(32'h0000_CAFE, 16'd0);     // nothing fits a zero sized block
    send_string(32'hAAAA_AAAA, 16'd0);
    send_string(32'h0000_0000, 16'hFFFF);
  endtask

  task automatic test_arena_limit();
    longint unsigned over_len;
    write_block_bytes(17'h1_0000);
    // a fresh block of this size cannot fit in the arena
    send_string(32'h1357_9BDF, 16'hFFFF);
    // fits in the current block but ends one byte past the arena
    over_len = ARENA_BYTES - (arena_base + arena_fill);
    if (over_len <= 65535) send_string(32'h2468_ACE0, LEN_W'(over_len));
    send_string(32'h1357_9BDF, 16'd0);
  endtask

  task automatic test_random_traffic(input logic [NEED_W-1:0] size, input int unsigned gap_pct,
                                     input int unsigned stall_pct);
    write_block_bytes(size);
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) send_string(pick_hash(), pick_length());
  endtask

  task automatic test_table_full();
    int unsigned attempts;
    write_block_bytes(17'd16);
    in_gap_pct    = 31;
    out_stall_pct = 31;
    attempts      = 0;
    while (table_entries < TABLE_ENTRIES - 1 && attempts < 400) begin
      send_string($urandom(), 16'd0);
      attempts++;
    end
    write_block_bytes(17'h1_0000);
    // last free entry takes the arena up to its very last byte
    if (table_entries == TABLE_ENTRIES - 1 && arena_base + arena_fill < ARENA_BYTES)
      send_string(32'h0F0F_0F0F, LEN_W'(ARENA_BYTES - 1 - arena_base - arena_fill));
    send_string($urandom(), 16'd0);
    send_string($urandom(), 16'hFFFF);     // full wins over too long
    send_string(table_hash[0], 16'd5);
    send_string(table_hash[table_entries - 1], 16'd0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_basic_insert();
    test_block_shrink();
    test_zero_block();
    test_arena_limit();
    test_random_traffic(17'd24, 0, 0);
    test_random_traffic(17'd1, 0, 0);
    test_random_traffic(17'd64, 67, 0);
    test_random_traffic(17'd300, 67, 0);
    test_random_traffic(17'd512, 0, 67);
    test_random_traffic(17'd2, 0, 67);
    test_random_traffic(17'd130, 31, 31);
    test_random_traffic(17'd1024, 31, 31);
    test_table_full();
    wait_drain();
    repeat (8) @(posedge clk);
    $display("%0d strings interned: %0d new, %0d hits, %0d table full, %0d too long, %0d no room",
             items_sent, status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    $display("table ended with %0d entries, arena used up to byte %0d, %0d mismatches",
             table_entries, arena_base + arena_fill, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
